>>> rtl/core/sud_pkg.sv
// ----------------------------------------------------------------------------
// sud_pkg
// shared width, mode codes and the per-stage work record of the divider
// ----------------------------------------------------------------------------
package sud_pkg;

   localparam int unsigned WIDTH = 32;

   // operand signedness modes
   localparam logic [1:0] MODE_UU = 2'd0;  // unsigned / unsigned
   localparam logic [1:0] MODE_SS = 2'd1;  // signed / signed
   localparam logic [1:0] MODE_US = 2'd2;  // unsigned dividend, signed divisor
   localparam logic [1:0] MODE_SU = 2'd3;  // signed dividend, unsigned divisor

   // record carried down the division pipe
   typedef struct packed {
      logic             n_neg;   // dividend was negative
      logic             d_neg;   // divisor was negative
      logic             d_zero;  // divisor is zero
      logic [WIDTH-1:0] nq;      // dividend bits shift out, quotient bits shift in
      logic [WIDTH-1:0] rem;     // partial remainder
      logic [WIDTH-1:0] den;     // divisor magnitude
   } work_type;

   function automatic logic [WIDTH-1:0] negate(input logic [WIDTH-1:0] v);
      negate = {WIDTH{1'b0}} - v;
   endfunction

endpackage

>>> rtl/core/sud_req_if.sv
// ----------------------------------------------------------------------------
// sud_req_if
// request channel: mode and operands with valid/ready
// ----------------------------------------------------------------------------
interface sud_req_if import sud_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [1:0]       mode;
   logic [WIDTH-1:0] dividend;
   logic [WIDTH-1:0] divisor;

   modport source (output valid, output mode, output dividend, output divisor,
                   input ready);
   modport sink   (input valid, input mode, input dividend, input divisor,
                   output ready);

endinterface

>>> rtl/core/sud_rsp_if.sv
// ----------------------------------------------------------------------------
// sud_rsp_if
// response channel: quotient and remainder with valid/ready
// ----------------------------------------------------------------------------
interface sud_rsp_if import sud_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] quotient;
   logic [WIDTH-1:0] remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink   (input valid, input quotient, input remainder, output ready);

endinterface

>>> rtl/core/signed_unsigned_integer_divider.sv
// ----------------------------------------------------------------------------
// signed_unsigned_integer_divider
// pipelined signed/unsigned restoring divider; without an rsp_chan stall, one operation per cycle
// ----------------------------------------------------------------------------
// usage:
//  - req_chan carries mode, dividend and divisor; rsp_chan returns quotient
//    and remainder, one response beat per request beat, in order
//  - modes: unsigned/unsigned, signed/signed, unsigned dividend with signed
//    divisor, signed dividend with unsigned divisor
//  - quotient truncates toward zero and wraps on overflow; remainder takes
//    the dividend's sign; a zero divisor returns zero for both
//  - the pipe has one entry stage for magnitudes, one stage per quotient bit
//    and one exit stage for signs
//  - throughput is one beat per cycle while rsp_chan accepts; each
//    quotient-bit stage holds one WIDTH+1 bit subtract, which sets the clock
//  - every stage has its own valid bit and loads whenever it is empty or
//    its successor moves, so bubbles close up under a stall and a new beat
//    is accepted while a finished response waits on rsp_chan
//  - when rsp_chan stalls, beats pile up behind the exit register; nothing
//    is dropped or repeated, and req_chan.ready falls only once every stage
//    is full
//  - synchronous reset clears all valid bits; the pipe is empty afterwards
// ----------------------------------------------------------------------------
module signed_unsigned_integer_divider import sud_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sud_req_if.sink    req_chan,
   sud_rsp_if.source  rsp_chan
);

   // stage k feeds step k; stage WIDTH feeds the exit stage
   logic     stg_valid [WIDTH+1];
   logic     stg_ready [WIDTH+1];
   work_type stg_data  [WIDTH+1];

   // entry: mode decode and operand magnitudes
   sud_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .mode      (req_chan.mode),
      .dividend  (req_chan.dividend),
      .divisor   (req_chan.divisor),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      sud_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   // exit: sign correction, zero-divisor rule, response register
   sud_fix u_fix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[WIDTH]),
      .in_ready  (stg_ready[WIDTH]),
      .in_data   (stg_data[WIDTH]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .quotient  (rsp_chan.quotient),
      .remainder (rsp_chan.remainder)
   );

endmodule

>>> rtl/core/sud_prep.sv
// ----------------------------------------------------------------------------
// sud_prep
// entry stage: decodes the mode and registers operand magnitudes and signs
// ----------------------------------------------------------------------------
module sud_prep import sud_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       mode,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             out_valid,
   input  logic             out_ready,
   output work_type         out_data
);

   logic     valid_ff;
   logic     valid_in;
   work_type data_ff;
   work_type data_in;
   logic     n_signed;
   logic     d_signed;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      n_signed       = (mode == MODE_SS) || (mode == MODE_SU);
      d_signed       = (mode == MODE_SS) || (mode == MODE_US);
      data_in.n_neg  = n_signed && dividend[WIDTH-1];
      data_in.d_neg  = d_signed && divisor[WIDTH-1];
      data_in.d_zero = (divisor == {WIDTH{1'b0}});
      data_in.nq     = data_in.n_neg ? negate(dividend) : dividend;
      data_in.den    = data_in.d_neg ? negate(divisor) : divisor;
      data_in.rem    = {WIDTH{1'b0}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/sud_step.sv
// ----------------------------------------------------------------------------
// sud_step
// one restoring shift-subtract step, registered
// ----------------------------------------------------------------------------
module sud_step import sud_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   logic             valid_ff;
   logic             valid_in;
   work_type         data_ff;
   work_type         data_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             take;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      // shifted remainder keeps its carry-out as the top bit
      trial       = {in_data.rem, in_data.nq[WIDTH-1]};
      diff        = trial - {1'b0, in_data.den};
      take        = !diff[WIDTH];
      data_in     = in_data;
      data_in.rem = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      data_in.nq  = {in_data.nq[WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/sud_fix.sv
// ----------------------------------------------------------------------------
// sud_fix
// exit stage: applies signs and the zero-divisor rule, holds the result beat
// ----------------------------------------------------------------------------
module sud_fix import sud_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  work_type         in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] quo_in;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] rem_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      if (in_data.d_zero) begin
         quo_in = {WIDTH{1'b0}};
         rem_in = {WIDTH{1'b0}};
      end else begin
         quo_in = (in_data.n_neg ^ in_data.d_neg) ? negate(in_data.nq) : in_data.nq;
         rem_in = in_data.n_neg ? negate(in_data.rem) : in_data.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign out_valid = valid_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
